FILE: rtl/pasc_pkg.sv
// shared types and constants of the primitive assembler with scissor cull
// no dependencies
package pasc_pkg;

    // primitive type codes
    localparam logic [2:0] PRIM_POINT     = 3'd0;
    localparam logic [2:0] PRIM_LINE      = 3'd1;
    localparam logic [2:0] PRIM_LINESTRIP = 3'd2;
    localparam logic [2:0] PRIM_TRI       = 3'd3;
    localparam logic [2:0] PRIM_TRISTRIP  = 3'd4;
    localparam logic [2:0] PRIM_FAN       = 3'd5;
    localparam logic [2:0] PRIM_SPRITE    = 3'd6;
    localparam logic [2:0] PRIM_INVALID   = 3'd7;

    // configuration register indexes
    localparam logic [2:0] REG_PRIM_TYPE      = 3'd0;
    localparam logic [2:0] REG_TEXTURE_ENABLE = 3'd1;
    localparam logic [2:0] REG_FIXED_TEXEL    = 3'd2;
    localparam logic [2:0] REG_SCISSOR_LEFT   = 3'd3;
    localparam logic [2:0] REG_SCISSOR_TOP    = 3'd4;
    localparam logic [2:0] REG_SCISSOR_RIGHT  = 3'd5;
    localparam logic [2:0] REG_SCISSOR_BOTTOM = 3'd6;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // IEEE single precision 1.0
    localparam logic [31:0] ONE_FLOAT_BITS = 32'h3F80_0000;

    // one assembled vertex
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [31:0] dep;
        logic [31:0] col;
        logic [31:0] fog;
        logic [31:0] u;
        logic [31:0] v;
        logic [31:0] w;
    } vtx_t;

endpackage

FILE: rtl/pasc_vtx_in_if.sv
// input channel: one vertex kick per item
// depends on nothing
interface pasc_vtx_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] depth;
    logic [31:0] rgba;
    logic [31:0] fog_word;
    logic [13:0] texel_u;
    logic [13:0] texel_v;
    logic [31:0] coord_s;
    logic [31:0] coord_t;
    logic [31:0] coord_q;
    logic        skip_draw;

    modport source (
        output valid, pos_x, pos_y, depth, rgba, fog_word, texel_u, texel_v,
               coord_s, coord_t, coord_q, skip_draw,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, depth, rgba, fog_word, texel_u, texel_v,
               coord_s, coord_t, coord_q, skip_draw,
        output ready
    );
endinterface

FILE: rtl/pasc_vtx_out_if.sv
// output channel: one emitted vertex per item
// depends on nothing
interface pasc_vtx_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [31:0] out_depth;
    logic [31:0] out_rgba;
    logic [31:0] out_fog;
    logic [31:0] out_u;
    logic [31:0] out_v;
    logic [31:0] out_w;
    logic [1:0]  corner;
    logic        last_vertex;

    modport source (
        output valid, out_x, out_y, out_depth, out_rgba, out_fog, out_u, out_v,
               out_w, corner, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_depth, out_rgba, out_fog, out_u, out_v,
               out_w, corner, last_vertex,
        output ready
    );
endinterface

FILE: rtl/pasc_cfg_if.sv
// configuration write channel: register index and write data
// depends on pasc_pkg
interface pasc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pasc_pkg::CFG_INDEX_W-1:0] index;
    logic [pasc_pkg::CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: rtl/primitive_assembler_scissor_cull.sv
// primitive assembler with scissor trivial reject, top level
// depends on pasc_pkg, pasc_vtx_in_if, pasc_vtx_out_if, pasc_cfg_if
//
// usage:
//   vtx_in takes one vertex kick per item. vtx_out gives the vertices of each
//   assembled primitive in order, with corner and last_vertex marking them.
//   cfg writes the seven registers (index 0..6); it is always ready. The user must
//   write it only while the block is idle; the block itself does not enforce this.
// path:
//   an accepted kick goes into the input register and from there, once the
//   buffer is free, into the primitive buffer, whose vertices then leave on vtx_out.
//   a primitive holds the single output port until its last vertex is taken,
//   and the next kick waits for the buffer: points run at one kick per cycle
//   while vtx_out.ready stays high, and no kick leaves the input register
//   before the last vertex of the buffered primitive is taken.
// reset: queue count, valids and registers clear (scissor right and bottom
//   to 65535); queue contents are undefined until written.
// stall:
//   while the receiver holds ready low the buffered primitive waits, one more
//   kick is held in the input register, then vtx_in.ready drops.
module primitive_assembler_scissor_cull (
    input  logic           clk,
    input  logic           rst_n,
    pasc_vtx_in_if.sink    vtx_in,
    pasc_vtx_out_if.source vtx_out,
    pasc_cfg_if.sink       cfg
);

    // configuration registers
    logic [2:0]  prim_type_reg;
    logic        texture_enable_reg;
    logic        fixed_texel_reg;
    logic [15:0] scissor_left_reg;
    logic [15:0] scissor_top_reg;
    logic [15:0] scissor_right_reg;
    logic [15:0] scissor_bottom_reg;

    // input register
    logic         a_valid_reg;
    logic [15:0]  a_x_reg;
    logic [15:0]  a_y_reg;
    logic [31:0]  a_dep_reg;
    logic [31:0]  a_col_reg;
    logic [31:0]  a_fog_reg;
    logic [13:0]  a_tu_reg;
    logic [13:0]  a_tv_reg;
    logic [31:0]  a_s_reg;
    logic [31:0]  a_t_reg;
    logic [31:0]  a_q_reg;
    logic         a_skip_reg;

    // vertex queue
    pasc_pkg::vtx_t q_reg [3];
    pasc_pkg::vtx_t q_next [3];
    logic [1:0]     q_cnt_reg;
    logic [1:0]     q_cnt_next;

    // primitive buffer feeding the output
    pasc_pkg::vtx_t p_reg [3];
    pasc_pkg::vtx_t p_next [3];
    logic           p_valid_reg;
    logic [1:0]     p_n_reg;
    logic [1:0]     p_idx_reg;
    logic [1:0]     p_n_next;
    logic           emit;

    logic           p_last;
    logic           p_free;
    logic           a_adv;
    logic           in_fire;
    logic           out_fire;
    pasc_pkg::vtx_t nv;
    pasc_pkg::vtx_t t [3];
    logic [1:0]     tc;
    logic [1:0]     need;
    logic [2:0]     lft;
    logic [2:0]     rgt;
    logic [2:0]     abv;
    logic [2:0]     blw;
    logic [2:0]     used;
    logic           reject;
    pasc_pkg::vtx_t ov;

    // handshakes
    assign p_last   = (p_idx_reg == p_n_reg - 2'd1);
    assign out_fire = p_valid_reg && vtx_out.ready;
    assign p_free   = !p_valid_reg || (vtx_out.ready && p_last);
    assign a_adv    = a_valid_reg && p_free;
    assign vtx_in.ready = !a_valid_reg || a_adv;
    assign in_fire  = vtx_in.valid && vtx_in.ready;
    assign cfg.ready = 1'b1;

    // build the new vertex
    always_comb
    begin
        nv.x   = a_x_reg;
        nv.y   = a_y_reg;
        nv.dep = a_dep_reg;
        nv.col = a_col_reg;
        nv.fog = a_fog_reg;
        if (!texture_enable_reg)
        begin
            nv.u = 32'd0;
            nv.v = 32'd0;
            nv.w = pasc_pkg::ONE_FLOAT_BITS;
        end
        else if (fixed_texel_reg)
        begin
            nv.u = {18'd0, a_tu_reg};
            nv.v = {18'd0, a_tv_reg};
            nv.w = pasc_pkg::ONE_FLOAT_BITS;
        end
        else
        begin
            nv.u = a_s_reg;
            nv.v = a_t_reg;
            nv.w = a_q_reg;
        end
    end

    // append to the queue, dropping the oldest entry when full
    always_comb
    begin
        t[0] = q_reg[0];
        t[1] = q_reg[1];
        t[2] = q_reg[2];
        unique case (q_cnt_reg)
            2'd0:
            begin
                t[0] = nv;
                tc   = 2'd1;
            end
            2'd1:
            begin
                t[1] = nv;
                tc   = 2'd2;
            end
            2'd2:
            begin
                t[2] = nv;
                tc   = 2'd3;
            end
            default:
            begin
                t[0] = q_reg[1];
                t[1] = q_reg[2];
                t[2] = nv;
                tc   = 2'd3;
            end
        endcase
    end

    // assemble by the primitive type rules
    always_comb
    begin
        unique case (prim_type_reg)
            pasc_pkg::PRIM_POINT:                         need = 2'd1;
            pasc_pkg::PRIM_LINE, pasc_pkg::PRIM_LINESTRIP,
            pasc_pkg::PRIM_SPRITE:                        need = 2'd2;
            default:                                      need = 2'd3;
        endcase

        q_next     = t;
        q_cnt_next = tc;
        p_next     = t;
        p_n_next   = 2'd0;

        if (prim_type_reg == pasc_pkg::PRIM_INVALID)
        begin
            q_next     = q_reg;
            q_cnt_next = 2'd0;
        end
        else if (tc >= need)
        begin
            unique case (prim_type_reg)
                pasc_pkg::PRIM_POINT:
                begin
                    q_next[0]  = t[1];
                    q_next[1]  = t[2];
                    q_cnt_next = tc - 2'd1;
                    p_n_next   = 2'd1;
                end
                pasc_pkg::PRIM_LINE, pasc_pkg::PRIM_SPRITE:
                begin
                    q_next[0]  = t[2];
                    q_cnt_next = tc - 2'd2;
                    p_n_next   = 2'd2;
                end
                pasc_pkg::PRIM_LINESTRIP:
                begin
                    q_next[0]  = t[1];
                    q_next[1]  = t[2];
                    q_cnt_next = tc - 2'd1;
                    p_n_next   = 2'd2;
                end
                pasc_pkg::PRIM_TRI:
                begin
                    q_cnt_next = 2'd0;
                    p_n_next   = 2'd3;
                end
                pasc_pkg::PRIM_TRISTRIP:
                begin
                    q_next[0]  = t[1];
                    q_next[1]  = t[2];
                    q_cnt_next = tc - 2'd1;
                    p_n_next   = 2'd3;
                end
                default:
                begin
                    // fan keeps the pivot and the newest vertex
                    q_next[1]  = t[2];
                    q_cnt_next = tc - 2'd1;
                    p_n_next   = 2'd3;
                end
            endcase
        end
    end

    // scissor trivial reject
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            used[i] = (2'(i) < p_n_next);
            lft[i]  = !used[i] || (t[i].x < scissor_left_reg);
            rgt[i]  = !used[i] || (t[i].x > scissor_right_reg);
            abv[i]  = !used[i] || (t[i].y < scissor_top_reg);
            blw[i]  = !used[i] || (t[i].y > scissor_bottom_reg);
        end
        if (p_n_next == 2'd1)
            reject = lft[0] || rgt[0] || abv[0] || blw[0];
        else
            reject = (&lft) || (&rgt) || (&abv) || (&blw);
        emit = (p_n_next != 2'd0) && !a_skip_reg && !reject;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prim_type_reg      <= pasc_pkg::PRIM_POINT;
            texture_enable_reg <= 1'b0;
            fixed_texel_reg    <= 1'b0;
            scissor_left_reg   <= 16'd0;
            scissor_top_reg    <= 16'd0;
            scissor_right_reg  <= 16'hFFFF;
            scissor_bottom_reg <= 16'hFFFF;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                pasc_pkg::REG_PRIM_TYPE:      prim_type_reg      <= cfg.data[2:0];
                pasc_pkg::REG_TEXTURE_ENABLE: texture_enable_reg <= cfg.data[0];
                pasc_pkg::REG_FIXED_TEXEL:    fixed_texel_reg    <= cfg.data[0];
                pasc_pkg::REG_SCISSOR_LEFT:   scissor_left_reg   <= cfg.data;
                pasc_pkg::REG_SCISSOR_TOP:    scissor_top_reg    <= cfg.data;
                pasc_pkg::REG_SCISSOR_RIGHT:  scissor_right_reg  <= cfg.data;
                pasc_pkg::REG_SCISSOR_BOTTOM: scissor_bottom_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            q_cnt_reg   <= 2'd0;
            p_valid_reg <= 1'b0;
            p_n_reg     <= 2'd0;
            p_idx_reg   <= 2'd0;
        end
        else
        begin
            if (in_fire)
                a_valid_reg <= 1'b1;
            else if (a_adv)
                a_valid_reg <= 1'b0;

            if (a_adv)
                q_cnt_reg <= q_cnt_next;

            if (a_adv && emit)
            begin
                p_valid_reg <= 1'b1;
                p_n_reg     <= p_n_next;
                p_idx_reg   <= 2'd0;
            end
            else if (out_fire)
            begin
                if (p_last)
                    p_valid_reg <= 1'b0;
                p_idx_reg <= p_idx_reg + 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_x_reg    <= vtx_in.pos_x;
            a_y_reg    <= vtx_in.pos_y;
            a_dep_reg  <= vtx_in.depth;
            a_col_reg  <= vtx_in.rgba;
            a_fog_reg  <= vtx_in.fog_word;
            a_tu_reg   <= vtx_in.texel_u;
            a_tv_reg   <= vtx_in.texel_v;
            a_s_reg    <= vtx_in.coord_s;
            a_t_reg    <= vtx_in.coord_t;
            a_q_reg    <= vtx_in.coord_q;
            a_skip_reg <= vtx_in.skip_draw;
        end
        if (a_adv)
            q_reg <= q_next;
        if (a_adv && emit)
            p_reg <= p_next;
    end

    // output vertex select
    always_comb
    begin
        case (p_idx_reg)
            2'd1:    ov = p_reg[1];
            2'd2:    ov = p_reg[2];
            default: ov = p_reg[0];
        endcase
    end

    assign vtx_out.valid       = p_valid_reg;
    assign vtx_out.out_x       = ov.x;
    assign vtx_out.out_y       = ov.y;
    assign vtx_out.out_depth   = ov.dep;
    assign vtx_out.out_rgba    = ov.col;
    assign vtx_out.out_fog     = ov.fog;
    assign vtx_out.out_u       = ov.u;
    assign vtx_out.out_v       = ov.v;
    assign vtx_out.out_w       = ov.w;
    assign vtx_out.corner      = p_idx_reg;
    assign vtx_out.last_vertex = p_last;

endmodule
